// File: rtl/core/scel_pkg.sv
// Shared types and constants for the staged circular event log.
// Depends on nothing; every other file but scel_ram imports it.
`timescale 1ns / 1ps

package scel_pkg;

  // Store sizes
  localparam int unsigned RING_DEPTH  = 256;
  localparam int unsigned STAGE_DEPTH = 16;

  // Derived widths: addresses, counts and the combined entry count
  localparam int unsigned RING_AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned RING_CW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned STAGE_AW = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
  localparam int unsigned STAGE_CW = $clog2(STAGE_DEPTH + 1);
  localparam int unsigned TOT_W    = $clog2(RING_DEPTH + STAGE_DEPTH + 1);

  // Fixed field widths of the stream beats
  localparam int unsigned EVENT_W = 64;
  localparam int unsigned INDEX_W = 9;
  localparam int unsigned TOTAL_W = 9;
  localparam int unsigned CMP_W   = (TOT_W > INDEX_W) ? TOT_W : INDEX_W;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_LOG   = 2'd0,
    OP_READ  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN,
    ST_RD_WAIT,
    ST_RESP
  } state_e;

  // Result of one item, handed from the sequencer to the output stage
  typedef struct packed {
    logic               status;
    logic [EVENT_W-1:0] entry;
    logic [TOTAL_W-1:0] total;
    logic               persist;
  } result_t;

  // Write and read requests towards the two memories
  typedef struct packed {
    logic                we;
    logic [RING_AW-1:0]  waddr;
    logic [EVENT_W-1:0]  wdata;
    logic [RING_AW-1:0]  raddr;
  } ring_req_t;

  typedef struct packed {
    logic                we;
    logic [STAGE_AW-1:0] waddr;
    logic [EVENT_W-1:0]  wdata;
    logic [STAGE_AW-1:0] raddr;
  } stage_req_t;

endpackage

// File: rtl/core/scel_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for both the ring store and the staging store.
`timescale 1ns / 1ps

module scel_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/scel_out.sv
// Output register of the event log: holds one result beat until it is taken.
// Depends on scel_pkg for the result type.
`timescale 1ns / 1ps

module scel_out
  import scel_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held beat leaves this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/core/scel_seq.sv
// Sequencer of the event log: counters, pointers and the read-modify-write
// steps over the ring and staging memories. Depends on scel_pkg.
`timescale 1ns / 1ps

module scel_seq
  import scel_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // incoming item
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  op_e                in_op_i,
  input  logic [EVENT_W-1:0] in_event_i,
  input  logic               in_crit_i,
  input  logic [INDEX_W-1:0] in_index_i,
  // memories
  output ring_req_t          ring_req_o,
  input  logic [EVENT_W-1:0] ring_rdata_i,
  output stage_req_t         stage_req_o,
  input  logic [EVENT_W-1:0] stage_rdata_i,
  // result towards the output register
  input  logic               out_free_i,
  output logic               out_load_o,
  output result_t            out_res_o
);

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [EVENT_W-1:0]  ev_q, ev_d;
  logic                crit_q, crit_d;
  logic [INDEX_W-1:0]  idx_q, idx_d;
  logic [RING_CW-1:0]  ring_count_q, ring_count_d;
  logic [RING_AW-1:0]  oldest_q, oldest_d;
  logic [RING_AW-1:0]  next_q, next_d;
  logic [STAGE_CW-1:0] stage_count_q, stage_count_d;
  logic                dirty_q, dirty_d;
  logic [STAGE_CW-1:0] rd_k_q, rd_k_d;
  logic                logged_q, logged_d;
  logic                rd_ring_q, rd_ring_d;
  logic                res_status_q, res_status_d;
  logic [EVENT_W-1:0]  res_ev_q, res_ev_d;
  logic                res_persist_q, res_persist_d;

  logic [TOT_W-1:0]    total;
  logic [CMP_W-1:0]    total_c, idx_c, ring_c, stage_off;
  logic [RING_AW:0]    ring_sum, ring_wrap;
  logic [RING_AW-1:0]  ring_rd_addr;
  logic                stage_full;

  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] ptr);
    logic [RING_AW-1:0] nxt;
    if (ptr == RING_AW'(RING_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

  // Entry count and logical-index mapping
  assign total     = TOT_W'(ring_count_q) + TOT_W'(stage_count_q);
  assign total_c   = CMP_W'(total);
  assign idx_c     = CMP_W'(idx_q);
  assign ring_c    = CMP_W'(ring_count_q);
  assign stage_off = idx_c - ring_c;
  assign ring_sum  = {1'b0, oldest_q} + {1'b0, idx_c[RING_AW-1:0]};
  assign ring_wrap = ring_sum - (RING_AW + 1)'(RING_DEPTH);
  assign ring_rd_addr = (ring_sum >= (RING_AW + 1)'(RING_DEPTH)) ?
                        ring_wrap[RING_AW-1:0] : ring_sum[RING_AW-1:0];
  assign stage_full = (stage_count_q == STAGE_CW'(STAGE_DEPTH));

  // Result beat, built from the final counters
  assign out_res_o.status  = res_status_q;
  assign out_res_o.entry   = res_ev_q;
  assign out_res_o.total   = total_c[TOTAL_W-1:0];
  assign out_res_o.persist = res_persist_q;

  // Next state and memory requests
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    ev_d          = ev_q;
    crit_d        = crit_q;
    idx_d         = idx_q;
    ring_count_d  = ring_count_q;
    oldest_d      = oldest_q;
    next_d        = next_q;
    stage_count_d = stage_count_q;
    dirty_d       = dirty_q;
    rd_k_d        = rd_k_q;
    logged_d      = logged_q;
    rd_ring_d     = rd_ring_q;
    res_status_d  = res_status_q;
    res_ev_d      = res_ev_q;
    res_persist_d = res_persist_q;

    ring_req_o       = '0;
    ring_req_o.raddr = ring_rd_addr;
    stage_req_o       = '0;
    stage_req_o.raddr = rd_k_q[STAGE_AW-1:0];

    in_ready_o = 1'b0;
    out_load_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d          = in_op_i;
          ev_d          = in_event_i;
          crit_d        = in_crit_i;
          idx_d         = in_index_i;
          logged_d      = 1'b0;
          res_status_d  = 1'b0;
          res_ev_d      = '0;
          res_persist_d = 1'b0;
          state_d       = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (op_q)
          OP_LOG: begin
            if (logged_q) begin
              // critical: flush the staging store after the event went in
              res_persist_d     = 1'b1;
              dirty_d           = 1'b0;
              stage_req_o.raddr = '0;
              rd_k_d            = STAGE_CW'(1);
              state_d           = ST_DRAIN;
            end else if (stage_full) begin
              // make room first; come back here to stage the event
              stage_req_o.raddr = '0;
              rd_k_d            = STAGE_CW'(1);
              state_d           = ST_DRAIN;
            end else begin
              stage_req_o.we    = 1'b1;
              stage_req_o.waddr = stage_count_q[STAGE_AW-1:0];
              stage_req_o.wdata = ev_q;
              stage_count_d     = stage_count_q + 1'b1;
              dirty_d           = 1'b1;
              logged_d          = 1'b1;
              state_d           = crit_q ? ST_EXEC : ST_RESP;
            end
          end
          OP_READ: begin
            if (idx_c >= total_c) begin
              res_status_d = 1'b1;
              state_d      = ST_RESP;
            end else begin
              rd_ring_d         = (idx_c < ring_c);
              stage_req_o.raddr = stage_off[STAGE_AW-1:0];
              state_d           = ST_RD_WAIT;
            end
          end
          OP_FLUSH: begin
            if (dirty_q && (stage_count_q != '0)) begin
              res_persist_d     = 1'b1;
              dirty_d           = 1'b0;
              stage_req_o.raddr = '0;
              rd_k_d            = STAGE_CW'(1);
              state_d           = ST_DRAIN;
            end else begin
              res_persist_d = dirty_q;
              dirty_d       = 1'b0;
              state_d       = ST_RESP;
            end
          end
          OP_CLEAR: begin
            ring_count_d  = '0;
            oldest_d      = '0;
            next_d        = '0;
            stage_count_d = '0;
            dirty_d       = 1'b0;
            state_d       = ST_RESP;
          end
          default: state_d = ST_RESP;
        endcase
      end

      ST_DRAIN: begin
        // one staged entry per cycle into the ring, overwriting the oldest when full
        ring_req_o.we    = 1'b1;
        ring_req_o.waddr = next_q;
        ring_req_o.wdata = stage_rdata_i;
        next_d           = ring_inc(next_q);
        if (ring_count_q < RING_CW'(RING_DEPTH)) begin
          ring_count_d = ring_count_q + 1'b1;
        end else begin
          oldest_d = ring_inc(oldest_q);
        end
        if (rd_k_q < stage_count_q) begin
          stage_req_o.raddr = rd_k_q[STAGE_AW-1:0];
          rd_k_d            = rd_k_q + 1'b1;
        end else begin
          stage_count_d = '0;
          state_d       = ((op_q == OP_LOG) && !logged_q) ? ST_EXEC : ST_RESP;
        end
      end

      ST_RD_WAIT: begin
        res_ev_d = rd_ring_q ? ring_rdata_i : stage_rdata_i;
        state_d  = ST_RESP;
      end

      ST_RESP: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: counters, pointers and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_count_q  <= '0;
      oldest_q      <= '0;
      next_q        <= '0;
      stage_count_q <= '0;
      dirty_q       <= 1'b0;
      rd_k_q        <= '0;
      logged_q      <= 1'b0;
      rd_ring_q     <= 1'b0;
      op_q          <= OP_LOG;
    end else begin
      ring_count_q  <= ring_count_d;
      oldest_q      <= oldest_d;
      next_q        <= next_d;
      stage_count_q <= stage_count_d;
      dirty_q       <= dirty_d;
      rd_k_q        <= rd_k_d;
      logged_q      <= logged_d;
      rd_ring_q     <= rd_ring_d;
      op_q          <= op_d;
    end
  end

  // Item payload and result under construction
  always_ff @(posedge clk_i) begin
    ev_q          <= ev_d;
    crit_q        <= crit_d;
    idx_q         <= idx_d;
    res_status_q  <= res_status_d;
    res_ev_q      <= res_ev_d;
    res_persist_q <= res_persist_d;
  end

endmodule

// File: rtl/core/staged_circular_event_log.sv
// Top level of the staged circular event log: stream ports, the two event
// memories, the sequencer and the output register. Depends on scel_pkg.
`timescale 1ns / 1ps

// Two-level trace buffer for 64-bit events. Each input beat gives one result
// beat. The block takes one item at a time; an accepted item runs through
// the EXEC state of the sequencer and, for a read, RD_WAIT for the
// registered memory read, and its result is loaded from RESP. Moving the
// staging store into the ring runs in the DRAIN state, one staged entry per
// cycle over the staging memory read port: a flush with entries pending
// drains them, a critical log first stages its event and then returns to
// EXEC to start the flush, and a log into a full staging store drains it
// before the event is staged. Results wait in an output register, so a
// stalled consumer holds the block only once a second result is ready.
// The stores need no clearing pass after reset or clear; only the counters
// and pointers are reset.

module staged_circular_event_log
  import scel_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] event_time, [39:32] event_type, [47:40] event_code,
  // [63:48] event_value, [64] is_critical, [73:65] read_index, [79:74] zero
  input  logic [79:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] entry_time, [39:32] entry_type, [47:40] entry_code,
  // [63:48] entry_value, [72:64] total_entries, [73] persist_request,
  // [79:74] zero
  output logic [79:0] m_axis_tdata,
  // [0] status
  output logic [0:0]  m_axis_tuser
);

  ring_req_t          ring_req;
  stage_req_t         stage_req;
  logic [EVENT_W-1:0] ring_rdata, stage_rdata;
  logic [EVENT_W-1:0] in_event;
  logic               out_free, out_load;
  result_t            seq_res, out_res;

  // Event word: time, type, code, value from the top bits down
  assign in_event = {s_axis_tdata[31:0], s_axis_tdata[39:32],
                     s_axis_tdata[47:40], s_axis_tdata[63:48]};

  scel_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_req.we),
    .waddr_i (ring_req.waddr),
    .wdata_i (ring_req.wdata),
    .raddr_i (ring_req.raddr),
    .rdata_o (ring_rdata)
  );

  scel_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (STAGE_DEPTH)
  ) u_stage_ram (
    .clk_i   (clk_i),
    .we_i    (stage_req.we),
    .waddr_i (stage_req.waddr),
    .wdata_i (stage_req.wdata),
    .raddr_i (stage_req.raddr),
    .rdata_o (stage_rdata)
  );

  scel_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_op_i       (op_e'(s_axis_tuser)),
    .in_event_i    (in_event),
    .in_crit_i     (s_axis_tdata[64]),
    .in_index_i    (s_axis_tdata[73:65]),
    .ring_req_o    (ring_req),
    .ring_rdata_i  (ring_rdata),
    .stage_req_o   (stage_req),
    .stage_rdata_i (stage_rdata),
    .out_free_i    (out_free),
    .out_load_o    (out_load),
    .out_res_o     (seq_res)
  );

  scel_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .res_i   (seq_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // Result beat packing
  assign m_axis_tdata = {6'd0, out_res.persist, out_res.total,
                         out_res.entry[15:0], out_res.entry[23:16],
                         out_res.entry[31:24], out_res.entry[63:32]};
  assign m_axis_tuser = out_res.status;

endmodule

// File: tb/sv/event_log_monitor.sv
// Checker for the staged circular event log: watches both stream channels,
// keeps its own copy of the ring and staging stores and compares every
// result beat. Depends on scel_pkg.
`timescale 1ns / 1ps

module event_log_monitor
  import scel_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [31:0] event_time, [39:32] event_type, [47:40] event_code,
  // [63:48] event_value, [64] is_critical, [73:65] read_index, [79:74] zero
  input  logic [79:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] entry_time, [39:32] entry_type, [47:40] entry_code,
  // [63:48] entry_value, [72:64] total_entries, [73] persist_request,
  // [79:74] zero
  input  logic [79:0] m_axis_tdata,
  // [0] status
  input  logic [0:0]  m_axis_tuser,
  output int          pending_o,
  output int          stored_total_o,
  output int          fail_count_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic               status;
    logic [31:0]        stamp;
    logic [7:0]         category;
    logic [7:0]         code;
    logic signed [15:0] value;
    logic [TOTAL_W-1:0] total;
    logic               persist;
  } log_reply_t;

  // Shadow copy of the block's stores and pointers
  logic [EVENT_W-1:0] ring_mem  [RING_DEPTH];
  logic [EVENT_W-1:0] stage_mem [STAGE_DEPTH];
  int unsigned        ring_cnt;
  int unsigned        stage_cnt;
  int unsigned        oldest;
  int unsigned        next_free;
  bit                 dirty;

  log_reply_t reply_q [$];
  log_reply_t want;

  // Overwrite-oldest insertion into the ring
  task automatic ring_push(input logic [EVENT_W-1:0] ev);
    ring_mem[next_free] = ev;
    next_free = (next_free + 1) % RING_DEPTH;
    if (ring_cnt < RING_DEPTH) ring_cnt++;
    else oldest = (oldest + 1) % RING_DEPTH;
  endtask

  // Move every staged event, oldest first, into the ring
  task automatic drain_stage();
    for (int k = 0; k < stage_cnt; k++) ring_push(stage_mem[k]);
    stage_cnt = 0;
  endtask

  // Flush only when something was logged since the last persist or clear
  task automatic persist_flush(output logic moved);
    moved = dirty;
    if (dirty) begin
      drain_stage();
      dirty = 1'b0;
    end
  endtask

  // Apply one accepted item to the shadow state and work out its reply
  task automatic predict_reply(input op_e op, input logic [79:0] d, output log_reply_t r);
    logic [EVENT_W-1:0] ev;
    int unsigned        idx;
    r   = '0;
    ev  = {d[31:0], d[39:32], d[47:40], d[63:48]};
    idx = {23'd0, d[73:65]};
    case (op)
      OP_LOG: begin
        // a full staging store empties into the ring before the new event
        if (stage_cnt >= STAGE_DEPTH) drain_stage();
        stage_mem[stage_cnt] = ev;
        stage_cnt++;
        dirty = 1'b1;
        if (d[64]) persist_flush(r.persist);
      end
      OP_READ: begin
        if (idx >= ring_cnt + stage_cnt) begin
          r.status = 1'b1;
        end else begin
          ev = (idx < ring_cnt) ? ring_mem[(oldest + idx) % RING_DEPTH]
                                : stage_mem[idx - ring_cnt];
          {r.stamp, r.category, r.code, r.value} = ev;
        end
      end
      OP_FLUSH: persist_flush(r.persist);
      default: begin
        ring_cnt  = 0;
        stage_cnt = 0;
        oldest    = 0;
        next_free = 0;
        dirty     = 1'b0;
      end
    endcase
    r.total = TOTAL_W'(ring_cnt + stage_cnt);
  endtask

  // Field-by-field comparison of a result beat with the oldest reply
  task automatic check_reply(input log_reply_t w);
    log_reply_t a;
    a.status   = m_axis_tuser[0];
    a.stamp    = m_axis_tdata[31:0];
    a.category = m_axis_tdata[39:32];
    a.code     = m_axis_tdata[47:40];
    a.value    = m_axis_tdata[63:48];
    a.total    = m_axis_tdata[72:64];
    a.persist  = m_axis_tdata[73];
    if (a != w || m_axis_tdata[79:74] != '0) begin
      if (fail_count_o < MAX_REPORTS) begin
        $display("%0t: mismatch, expected st=%0d t=%h ty=%h cd=%h v=%0d tot=%0d p=%0d pad=0",
                 $time, w.status, w.stamp, w.category, w.code, w.value, w.total, w.persist);
        $display("%0t:           actual st=%0d t=%h ty=%h cd=%h v=%0d tot=%0d p=%0d pad=%h",
                 $time, a.status, a.stamp, a.category, a.code, a.value, a.total, a.persist,
                 m_axis_tdata[79:74]);
      end
      fail_count_o++;
    end
  endtask

  // Track input beats, then result beats, on each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_cnt     = 0;
      stage_cnt    = 0;
      oldest       = 0;
      next_free    = 0;
      dirty        = 1'b0;
      fail_count_o = 0;
      reply_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_reply(op_e'(s_axis_tuser), s_axis_tdata, want);
        reply_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          if (fail_count_o < MAX_REPORTS)
            $display("%0t: result beat with no item awaiting it", $time);
          fail_count_o++;
        end else begin
          check_reply(reply_q.pop_front());
        end
      end
    end
    pending_o      = reply_q.size();
    stored_total_o = ring_cnt + stage_cnt;
  end

endmodule

// File: tb/sv/tb.sv
// Top of the event log testbench: clock, reset, directed and random item
// beats, result back-pressure and the verdict. Depends on scel_pkg, the
// block and event_log_monitor.
`timescale 1ns / 1ps

module tb;
  import scel_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_ITEMS  = 850;
  localparam int PHASE_B_START = 450;
  localparam int QUIET_START   = 750;
  localparam int MAX_INDEX     = RING_DEPTH + STAGE_DEPTH - 1;

  typedef struct {
    op_e         op;
    logic        crit;
    logic [8:0]  idx;
    logic [31:0] stamp;
    logic [7:0]  category;
    logic [7:0]  code;
    logic [15:0] value;
  } log_cmd_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = OP_LOG;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int pending;
  int stored_total;
  int fail_count;
  int cycle_count = 0;
  int stall_left  = 0;
  bit quiet_phase = 1'b0;

  always #2 clk_i = ~clk_i;

  staged_circular_event_log dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  event_log_monitor monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .pending_o      (pending),
    .stored_total_o (stored_total),
    .fail_count_o   (fail_count)
  );

  // Result side drops ready at random, in bursts, outside the quiet phase
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** staged_circular_event_log: FAILED **");
      $finish;
    end
  end

  // Present one beat (called just after a falling edge) and wait for it to go
  task automatic drive_beat(input log_cmd_t c);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.op;
    s_axis_tdata  <= {6'b0, c.idx, c.crit, c.value, c.code, c.category, c.stamp};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_fixed(input op_e op, input logic crit, input int idx,
                            input logic [31:0] stamp, input logic [7:0] category,
                            input logic [7:0] code, input logic [15:0] value);
    log_cmd_t c;
    c = '{op, crit, idx[8:0], stamp, category, code, value};
    @(negedge clk_i);
    drive_beat(c);
  endtask

  // Random item; read indices mostly land inside the stored entries
  task automatic send_random(input int log_w, input int flush_w, input int clear_w,
                             input int crit_div);
    log_cmd_t c;
    int       pick;
    int       sel;
    @(negedge clk_i);
    pick       = $urandom_range(0, 99);
    sel        = $urandom_range(0, 9);
    c.stamp    = $urandom;
    c.category = 8'($urandom);
    c.code     = 8'($urandom);
    c.value    = 16'($urandom);
    c.crit     = 1'($urandom_range(0, 1));
    if (sel == 0 || stored_total == 0) c.idx = 9'($urandom_range(0, MAX_INDEX));
    else if (sel < 3) c.idx = 9'((stored_total > MAX_INDEX) ? MAX_INDEX
                                 : stored_total - 1 + $urandom_range(0, 1));
    else c.idx = 9'($urandom_range(0, stored_total - 1));
    if (pick < clear_w) begin
      c.op = OP_CLEAR;
    end else if (pick < clear_w + flush_w) begin
      c.op = OP_FLUSH;
    end else if (pick < clear_w + flush_w + log_w) begin
      c.op   = OP_LOG;
      c.crit = ($urandom_range(1, crit_div) == 1);
    end else begin
      c.op = OP_READ;
    end
    drive_beat(c);
  endtask

  // Optional sender gap with valid low, outside the quiet phase
  task automatic idle_gap();
    int n;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Hold the sender until every outstanding reply has come back
  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty log, field extremes, flush rules, critical log, clear
    send_fixed(OP_FLUSH, 1'b0, 0, '0, '0, '0, '0);
    send_fixed(OP_READ,  1'b0, 0, '0, '0, '0, '0);
    send_fixed(OP_CLEAR, 1'b0, 0, '0, '0, '0, '0);
    send_fixed(OP_LOG,   1'b0, 0, 32'h0, 8'h00, 8'h00, 16'h8000);
    send_fixed(OP_LOG,   1'b0, MAX_INDEX, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'h7FFF);
    send_fixed(OP_LOG,   1'b0, 0, 32'h8000_0001, 8'h80, 8'h01, 16'hFFFF);
    send_fixed(OP_READ,  1'b0, 0, '0, '0, '0, '0);
    send_fixed(OP_READ,  1'b0, 2, '0, '0, '0, '0);
    send_fixed(OP_READ,  1'b0, 3, '0, '0, '0, '0);
    send_fixed(OP_READ,  1'b0, MAX_INDEX, '0, '0, '0, '0);
    send_fixed(OP_FLUSH, 1'b0, 0, '0, '0, '0, '0);
    send_fixed(OP_FLUSH, 1'b0, 0, '0, '0, '0, '0);
    send_fixed(OP_LOG,   1'b1, 0, 32'h1234_5678, 8'h5A, 8'hA5, 16'h0001);
    send_fixed(OP_LOG,   1'b0, 0, 32'h0000_0002, 8'h01, 8'hFE, 16'hFFFE);
    send_fixed(OP_READ,  1'b0, 3, '0, '0, '0, '0);
    send_fixed(OP_READ,  1'b0, 4, '0, '0, '0, '0);
    send_fixed(OP_READ,  1'b1, 0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_fixed(OP_CLEAR, 1'b1, MAX_INDEX, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_fixed(OP_READ,  1'b0, 0, '0, '0, '0, '0);
    send_fixed(OP_FLUSH, 1'b0, 0, '0, '0, '0, '0);
    send_fixed(OP_LOG,   1'b1, 0, 32'hDEAD_BEEF, 8'h42, 8'h24, 16'h8001);
    send_fixed(OP_READ,  1'b0, 0, '0, '0, '0, '0);

    // Random: first fill and overflow the ring with few flushes, then a
    // mix with flushes, critical logs and the odd clear
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PHASE_B_START || $urandom_range(0, 99) == 0) hold_until_drained();
      quiet_phase = (i >= QUIET_START);
      if (i < PHASE_B_START) send_random(75, 3, 0, 40);
      else send_random(45, 10, 1, 6);
      idle_gap();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** staged_circular_event_log: PASSED **");
    end else begin
      $display("** staged_circular_event_log: FAILED **");
    end
    $finish;
  end

endmodule
